### sv/euc_pkg.sv
package euc_pkg;

  localparam int EPOCH_W    = 38;
  localparam int DAYS_W     = 22;
  localparam int SOD_W      = 17;
  localparam int DOE_W      = 18;
  localparam int ERA_W      = 5;
  localparam int YEAR_W     = 14;
  localparam int PIPE_DEPTH = 11;

  localparam logic [EPOCH_W-1:0] MAX_EPOCH = 38'd253402300799;

  // 86400 = 2^7 * 675: low seven bits pass straight into the second of day
  localparam int DAY_LO_W = 7;
  localparam int DAY_ODD  = 675;

  localparam int ERA_SHIFT = 719468;
  localparam int ERA_DAYS  = 146097;
  localparam int CENT_DAYS = 36524;
  localparam int QUAD_DAYS = 1460;
  localparam int YEAR_DAYS = 365;

  // Reciprocals rounded up; each shift is wide enough that the quotient is
  // exact over the whole width of the dividend.
  localparam int K675   = 41;
  localparam int M675_W = 32;
  localparam logic [M675_W-1:0] M675 =
    M675_W'(((64'd1 << K675) + 64'(DAY_ODD) - 64'd1) / 64'(DAY_ODD));

  localparam int KERA   = 40;
  localparam int MERA_W = 23;
  localparam logic [MERA_W-1:0] MERA =
    MERA_W'(((64'd1 << KERA) + 64'(ERA_DAYS) - 64'd1) / 64'(ERA_DAYS));

  localparam int K1460   = 29;
  localparam int M1460_W = 19;
  localparam logic [M1460_W-1:0] M1460 =
    M1460_W'(((64'd1 << K1460) + 64'(QUAD_DAYS) - 64'd1) / 64'(QUAD_DAYS));

  localparam int K365   = 27;
  localparam int M365_W = 19;
  localparam logic [M365_W-1:0] M365 =
    M365_W'(((64'd1 << K365) + 64'(YEAR_DAYS) - 64'd1) / 64'(YEAR_DAYS));

  localparam int K153   = 19;
  localparam int M153_W = 12;
  localparam logic [M153_W-1:0] M153 =
    M153_W'(((64'd1 << K153) + 64'd152) / 64'd153);

  localparam int K60   = 23;
  localparam int M60_W = 18;
  localparam logic [M60_W-1:0] M60 =
    M60_W'(((64'd1 << K60) + 64'd59) / 64'd60);

  localparam int K60H   = 17;
  localparam int M60H_W = 12;
  localparam logic [M60H_W-1:0] M60H =
    M60H_W'(((64'd1 << K60H) + 64'd59) / 64'd60);

  typedef struct packed {
    logic [DAYS_W-1:0] days;
    logic [SOD_W-1:0]  sod;
    logic              oor;
  } split_t;

  typedef struct packed {
    logic [8:0]        yday;
    logic [YEAR_W-1:0] year;
    logic [3:0]        month;
    logic [4:0]        mday;
    logic [2:0]        wday;
    logic              oor;
  } civil_t;

  typedef struct packed {
    logic [5:0]       sec;
    logic [5:0]       min;
    logic [4:0]       hr;
    logic [SOD_W-1:0] sod;
  } clock_t;

endpackage

### sv/euc_pipe_ctrl.sv
module euc_pipe_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            out_ready,
  output logic                            in_ready,
  output logic                            out_valid,
  output logic [euc_pkg::PIPE_DEPTH-1:0]  en
);

  localparam int N = euc_pkg::PIPE_DEPTH;

  logic [N-1:0] valid_r;
  logic [N-1:0] valid_nxt;

  // a stage moves when it is empty or the stage after it moves
  assign en[N-1] = !valid_r[N-1] || out_ready;
  for (genvar k = 0; k < N - 1; k++) begin : g_en
    assign en[k] = !valid_r[k] || en[k+1];
  end

  assign valid_nxt = ({valid_r[N-2:0], in_valid} & en) | (valid_r & ~en);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = valid_r[N-1];

  a_stall_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (($past(valid_r & ~en) & ~valid_r) == '0))
    else $error("stalled stage dropped its request");

  a_bubble_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !(&valid_r) |-> in_ready)
    else $error("pipeline has a free stage but refuses input");

  a_one_in: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> ($countones(valid_r) <= $countones($past(valid_r)) + 1))
    else $error("more than one request entered in a cycle");

endmodule

### sv/euc_day_split.sv
module euc_day_split (
  input  logic                          clk,
  input  logic [2:0]                    en,
  input  logic [euc_pkg::EPOCH_W-1:0]   epoch_seconds,
  output euc_pkg::split_t               split
);

  localparam int X_W = euc_pkg::EPOCH_W - euc_pkg::DAY_LO_W;
  localparam int R_W = euc_pkg::SOD_W - euc_pkg::DAY_LO_W;
  localparam int P_W = X_W + euc_pkg::M675_W;

  logic [euc_pkg::EPOCH_W-1:0]  t_r;
  logic [X_W-1:0]               x_r;
  logic [euc_pkg::DAY_LO_W-1:0] lo_r;
  logic [euc_pkg::DAYS_W-1:0]   days_r;
  logic                         oor_r;
  euc_pkg::split_t              split_r;

  logic [P_W-1:0] prod;
  logic [X_W-1:0] rem;

  assign prod = P_W'(t_r[euc_pkg::EPOCH_W-1:euc_pkg::DAY_LO_W]) * P_W'(euc_pkg::M675);
  // remainder of the odd factor, always below 675
  assign rem  = x_r - X_W'(days_r) * X_W'(euc_pkg::DAY_ODD);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      t_r <= epoch_seconds;
    end
    if (en[1]) begin
      x_r    <= t_r[euc_pkg::EPOCH_W-1:euc_pkg::DAY_LO_W];
      lo_r   <= t_r[euc_pkg::DAY_LO_W-1:0];
      days_r <= prod[euc_pkg::K675+euc_pkg::DAYS_W-1:euc_pkg::K675];
      oor_r  <= t_r > euc_pkg::MAX_EPOCH;
    end
    if (en[2]) begin
      split_r.days <= days_r;
      split_r.sod  <= {rem[R_W-1:0], lo_r};
      split_r.oor  <= oor_r;
    end
  end

  assign split = split_r;

endmodule

### sv/euc_civil.sv
module euc_civil (
  input  logic             clk,
  input  logic [6:0]       en,
  input  euc_pkg::split_t  split,
  output euc_pkg::civil_t  civil
);

  localparam int DW   = euc_pkg::DAYS_W;
  localparam int OW   = euc_pkg::DOE_W;
  localparam int EP_W = DW + euc_pkg::MERA_W;
  localparam int QP_W = OW + euc_pkg::M1460_W;
  localparam int YP_W = OW + euc_pkg::M365_W;
  localparam int MP_W = 11 + euc_pkg::M153_W;
  localparam logic [8:0] MAR_TO_JAN   = 9'd306;
  localparam logic [8:0] JAN_FEB_DAYS = 9'd59;

  typedef struct packed {
    logic [euc_pkg::ERA_W-1:0] era;
    logic [2:0]                wday;
    logic                      oor;
  } carry_t;

  // first day of each month counted from 1 March
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] d;
    unique case (mp)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd61;
      4'd3:    d = 9'd92;
      4'd4:    d = 9'd122;
      4'd5:    d = 9'd153;
      4'd6:    d = 9'd184;
      4'd7:    d = 9'd214;
      4'd8:    d = 9'd245;
      4'd9:    d = 9'd275;
      4'd10:   d = 9'd306;
      4'd11:   d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  logic [DW-1:0]             s4_z_r;
  logic [euc_pkg::ERA_W-1:0] s4_era_r;
  logic [5:0]                s4_wsum_r;
  logic                      s4_oor_r;
  logic [OW-1:0]             s5_doe_r;
  carry_t                    s5_cy_r;
  logic [OW-1:0]             s6_n_r;
  logic [OW-1:0]             s6_doe_r;
  carry_t                    s6_cy_r;
  logic [8:0]                s7_yoe_r;
  logic [OW-1:0]             s7_doe_r;
  carry_t                    s7_cy_r;
  logic [8:0]                s8_doy_r;
  logic [8:0]                s8_yoe_r;
  carry_t                    s8_cy_r;
  logic [3:0]                s9_mp_r;
  logic [8:0]                s9_w_r;
  logic [8:0]                s9_yday_r;
  logic [8:0]                s9_doy_r;
  carry_t                    s9_cy_r;
  euc_pkg::civil_t           civil_r;

  logic [DW-1:0]   z;
  logic [EP_W-1:0] era_prod;
  logic [23:0]     dp4;
  logic [5:0]      wsum;
  logic [3:0]      wfold;
  logic [2:0]      wday;
  logic [OW-1:0]   doe;
  logic [QP_W-1:0] quad_prod;
  logic [2:0]      cents;
  logic [OW-1:0]   n;
  logic [YP_W-1:0] yoe_prod;
  logic [1:0]      yoe_cents;
  logic [OW-1:0]   doy_full;
  logic [10:0]     mp_arg;
  logic [MP_W-1:0] mp_prod;
  logic            after_feb;
  logic [8:0]      w;
  logic            leap;
  logic [8:0]      yday;
  logic [8:0]      mstart;
  logic [3:0]      month;

  always_comb begin
    z        = split.days + DW'(euc_pkg::ERA_SHIFT);
    era_prod = EP_W'(z) * EP_W'(euc_pkg::MERA);
    // 8 = 1 mod 7: octal digit sum keeps the residue
    dp4  = 24'(split.days) + 24'd4;
    wsum = '0;
    for (int k = 0; k < 8; k++) begin
      wsum = wsum + 6'(dp4[3*k +: 3]);
    end

    wfold = 4'(s4_wsum_r[5:3]) + 4'(s4_wsum_r[2:0]);
    if (wfold >= 4'd14) begin
      wday = 3'd0;
    end else if (wfold >= 4'd7) begin
      wday = 3'(wfold - 4'd7);
    end else begin
      wday = 3'(wfold);
    end
    doe = OW'(s4_z_r - DW'(s4_era_r) * DW'(euc_pkg::ERA_DAYS));

    quad_prod = QP_W'(s5_doe_r) * QP_W'(euc_pkg::M1460);
    cents = 3'(s5_doe_r >= OW'(euc_pkg::CENT_DAYS))
          + 3'(s5_doe_r >= OW'(2 * euc_pkg::CENT_DAYS))
          + 3'(s5_doe_r >= OW'(3 * euc_pkg::CENT_DAYS))
          + 3'(s5_doe_r >= OW'(4 * euc_pkg::CENT_DAYS));
    n = s5_doe_r - OW'(quad_prod[euc_pkg::K1460+6:euc_pkg::K1460]) + OW'(cents)
      - OW'(s5_doe_r == OW'(4 * euc_pkg::CENT_DAYS));

    yoe_prod = YP_W'(s6_n_r) * YP_W'(euc_pkg::M365);

    yoe_cents = 2'(s7_yoe_r >= 9'd100) + 2'(s7_yoe_r >= 9'd200) + 2'(s7_yoe_r >= 9'd300);
    doy_full  = s7_doe_r - (OW'(s7_yoe_r) * OW'(euc_pkg::YEAR_DAYS)
              + OW'(s7_yoe_r[8:2]) - OW'(yoe_cents));

    mp_arg    = 11'(s8_doy_r) * 11'd5 + 11'd2;
    mp_prod   = MP_W'(mp_arg) * MP_W'(euc_pkg::M153);
    // January and February close the March-based year
    after_feb = s8_doy_r >= MAR_TO_JAN;
    w         = s8_yoe_r + 9'(after_feb);
    leap      = (w[1:0] == 2'd0) && !(w == 9'd100 || w == 9'd200 || w == 9'd300);
    yday      = after_feb ? s8_doy_r - MAR_TO_JAN
                          : s8_doy_r + JAN_FEB_DAYS + 9'(leap);

    mstart = month_start(s9_mp_r);
    month  = (s9_mp_r < 4'd10) ? s9_mp_r + 4'd2 : s9_mp_r - 4'd10;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s4_z_r    <= z;
      s4_era_r  <= era_prod[euc_pkg::KERA+euc_pkg::ERA_W-1:euc_pkg::KERA];
      s4_wsum_r <= wsum;
      s4_oor_r  <= split.oor;
    end
    if (en[1]) begin
      s5_doe_r     <= doe;
      s5_cy_r.era  <= s4_era_r;
      s5_cy_r.wday <= wday;
      s5_cy_r.oor  <= s4_oor_r;
    end
    if (en[2]) begin
      s6_n_r   <= n;
      s6_doe_r <= s5_doe_r;
      s6_cy_r  <= s5_cy_r;
    end
    if (en[3]) begin
      s7_yoe_r <= yoe_prod[euc_pkg::K365+8:euc_pkg::K365];
      s7_doe_r <= s6_doe_r;
      s7_cy_r  <= s6_cy_r;
    end
    if (en[4]) begin
      s8_doy_r <= doy_full[8:0];
      s8_yoe_r <= s7_yoe_r;
      s8_cy_r  <= s7_cy_r;
    end
    if (en[5]) begin
      s9_mp_r   <= mp_prod[euc_pkg::K153+3:euc_pkg::K153];
      s9_w_r    <= w;
      s9_yday_r <= yday;
      s9_doy_r  <= s8_doy_r;
      s9_cy_r   <= s8_cy_r;
    end
    if (en[6]) begin
      civil_r.yday  <= s9_yday_r;
      civil_r.year  <= euc_pkg::YEAR_W'(s9_cy_r.era) * euc_pkg::YEAR_W'(400)
                     + euc_pkg::YEAR_W'(s9_w_r);
      civil_r.month <= month;
      civil_r.mday  <= 5'(s9_doy_r - mstart + 9'd1);
      civil_r.wday  <= s9_cy_r.wday;
      civil_r.oor   <= s9_cy_r.oor;
    end
  end

  assign civil = civil_r;

endmodule

### sv/euc_clock.sv
module euc_clock (
  input  logic                       clk,
  input  logic [6:0]                 en,
  input  logic [euc_pkg::SOD_W-1:0]  sod,
  output euc_pkg::clock_t            ck
);

  localparam int SW   = euc_pkg::SOD_W;
  localparam int MT_W = 11;
  localparam int P1_W = SW + euc_pkg::M60_W;
  localparam int P2_W = MT_W + euc_pkg::M60H_W;
  localparam int DLY  = 5;

  logic [MT_W-1:0] s4_mt_r;
  logic [SW-1:0]   s4_sod_r;
  logic [MT_W-1:0] s5_mt_r;
  logic [SW-1:0]   s5_sod_r;
  logic [5:0]      s5_sec_r;
  logic [4:0]      s5_hr_r;
  euc_pkg::clock_t dly_r [DLY];

  logic [P1_W-1:0] mt_prod;
  logic [P2_W-1:0] hr_prod;
  logic [SW-1:0]   sec_full;
  logic [MT_W-1:0] min_full;

  assign mt_prod  = P1_W'(sod) * P1_W'(euc_pkg::M60);
  assign hr_prod  = P2_W'(s4_mt_r) * P2_W'(euc_pkg::M60H);
  assign sec_full = s4_sod_r - SW'(s4_mt_r) * SW'(60);
  assign min_full = s5_mt_r - MT_W'(s5_hr_r) * MT_W'(60);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s4_mt_r  <= mt_prod[euc_pkg::K60+MT_W-1:euc_pkg::K60];
      s4_sod_r <= sod;
    end
    if (en[1]) begin
      s5_mt_r  <= s4_mt_r;
      s5_sod_r <= s4_sod_r;
      s5_sec_r <= sec_full[5:0];
      s5_hr_r  <= hr_prod[euc_pkg::K60H+4:euc_pkg::K60H];
    end
    if (en[2]) begin
      dly_r[0].sec <= s5_sec_r;
      dly_r[0].min <= min_full[5:0];
      dly_r[0].hr  <= s5_hr_r;
      dly_r[0].sod <= s5_sod_r;
    end
    // hold the time of day level with the calendar path
    for (int k = 1; k < DLY; k++) begin
      if (en[2+k]) begin
        dly_r[k] <= dly_r[k-1];
      end
    end
  end

  assign ck = dly_r[DLY-1];

endmodule

### sv/epoch_seconds_to_utc_calendar_top.sv
// Unix seconds to UTC calendar converter.
// Input channel: in_valid / in_ready carry one in_epoch_seconds per request.
// Output channel: out_valid / out_ready carry second, minute, hour,
// day_of_year, years_since_1900, month, day_of_month, weekday, the
// in_daylight flag and out_of_range; when out_of_range is set every other
// field is zero.
// Pipeline of eleven register stages: one request is taken every cycle
// while the receiver keeps out_ready high. The reciprocal multiplies of the
// day split and of the era, year-of-era and month steps set the stage count.
// A stalled receiver holds the output register; in_ready then follows from
// the first free stage, so requests keep entering until all eleven stages are
// full. in_ready is combinational from out_ready.
// Configuration: cfg_we writes cfg_data into register cfg_index at the
// clock edge (0..5: dst start month, day, second; std start month, day,
// second); other indexes are ignored. Write only while the pipeline is empty.
// Reset (rst_n low, synchronous) empties the pipeline and restores the
// daylight-saving registers to March 1st 02:00 and October 1st 03:00.
module epoch_seconds_to_utc_calendar_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [euc_pkg::EPOCH_W-1:0]   in_epoch_seconds,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [5:0]                    out_second,
  output logic [5:0]                    out_minute,
  output logic [4:0]                    out_hour,
  output logic [8:0]                    out_day_of_year,
  output logic [12:0]                   out_years_since_1900,
  output logic [3:0]                    out_month,
  output logic [4:0]                    out_day_of_month,
  output logic [2:0]                    out_weekday,
  output logic                          out_in_daylight,
  output logic                          out_out_of_range,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [16:0]                   cfg_data
);

  localparam int LAST = euc_pkg::PIPE_DEPTH - 1;
  localparam logic [2:0] CFG_DST_MONTH  = 3'd0;
  localparam logic [2:0] CFG_DST_DAY    = 3'd1;
  localparam logic [2:0] CFG_DST_SECOND = 3'd2;
  localparam logic [2:0] CFG_STD_MONTH  = 3'd3;
  localparam logic [2:0] CFG_STD_DAY    = 3'd4;
  localparam logic [2:0] CFG_STD_SECOND = 3'd5;
  localparam logic [euc_pkg::YEAR_W-1:0] YEAR_BASE = 14'd1900;

  logic [euc_pkg::PIPE_DEPTH-1:0] en;
  euc_pkg::split_t                split;
  euc_pkg::civil_t                civil;
  euc_pkg::clock_t                ck;

  logic [3:0]  dst_month_r;
  logic [4:0]  dst_day_r;
  logic [16:0] dst_second_r;
  logic [3:0]  std_month_r;
  logic [4:0]  std_day_r;
  logic [16:0] std_second_r;

  logic [5:0]  out_second_r;
  logic [5:0]  out_minute_r;
  logic [4:0]  out_hour_r;
  logic [8:0]  out_day_of_year_r;
  logic [12:0] out_years_since_1900_r;
  logic [3:0]  out_month_r;
  logic [4:0]  out_day_of_month_r;
  logic [2:0]  out_weekday_r;
  logic        out_in_daylight_r;
  logic        out_out_of_range_r;

  logic in_season;
  logic edge_ok;
  logic daylight;

  euc_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .en        (en)
  );

  euc_day_split u_split (
    .clk           (clk),
    .en            (en[2:0]),
    .epoch_seconds (in_epoch_seconds),
    .split         (split)
  );

  euc_civil u_civil (
    .clk   (clk),
    .en    (en[9:3]),
    .split (split),
    .civil (civil)
  );

  euc_clock u_clock (
    .clk (clk),
    .en  (en[9:3]),
    .sod (split.sod),
    .ck  (ck)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dst_month_r  <= 4'd2;
      dst_day_r    <= 5'd1;
      dst_second_r <= 17'd7200;
      std_month_r  <= 4'd9;
      std_day_r    <= 5'd1;
      std_second_r <= 17'd10800;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DST_MONTH:  dst_month_r  <= cfg_data[3:0];
        CFG_DST_DAY:    dst_day_r    <= cfg_data[4:0];
        CFG_DST_SECOND: dst_second_r <= cfg_data;
        CFG_STD_MONTH:  std_month_r  <= cfg_data[3:0];
        CFG_STD_DAY:    std_day_r    <= cfg_data[4:0];
        CFG_STD_SECOND: std_second_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // season wraps round the year end when standard time resumes no later
  // in the year than daylight saving begins
  always_comb begin
    if (std_month_r > dst_month_r) begin
      in_season = civil.month >= dst_month_r && civil.month < std_month_r;
    end else begin
      in_season = civil.month >= dst_month_r || civil.month < std_month_r;
    end
    priority if (civil.month == dst_month_r) begin
      edge_ok = civil.mday > dst_day_r
             || (civil.mday == dst_day_r && ck.sod >= dst_second_r);
    end else if (civil.month == std_month_r) begin
      edge_ok = civil.mday < std_day_r
             || (civil.mday == std_day_r && ck.sod < std_second_r);
    end else begin
      edge_ok = 1'b1;
    end
    daylight = in_season && edge_ok;
  end

  always_ff @(posedge clk) begin
    if (en[LAST]) begin
      out_second_r           <= civil.oor ? '0 : ck.sec;
      out_minute_r           <= civil.oor ? '0 : ck.min;
      out_hour_r             <= civil.oor ? '0 : ck.hr;
      out_day_of_year_r      <= civil.oor ? '0 : civil.yday;
      out_years_since_1900_r <= civil.oor ? '0 : 13'(civil.year - YEAR_BASE);
      out_month_r            <= civil.oor ? '0 : civil.month;
      out_day_of_month_r     <= civil.oor ? '0 : civil.mday;
      out_weekday_r          <= civil.oor ? '0 : civil.wday;
      out_in_daylight_r      <= !civil.oor && daylight;
      out_out_of_range_r     <= civil.oor;
    end
  end

  assign out_second           = out_second_r;
  assign out_minute           = out_minute_r;
  assign out_hour             = out_hour_r;
  assign out_day_of_year      = out_day_of_year_r;
  assign out_years_since_1900 = out_years_since_1900_r;
  assign out_month            = out_month_r;
  assign out_day_of_month     = out_day_of_month_r;
  assign out_weekday          = out_weekday_r;
  assign out_in_daylight      = out_in_daylight_r;
  assign out_out_of_range     = out_out_of_range_r;

endmodule

### tb/tb_epoch_seconds_to_utc_calendar_top.sv
module tb_epoch_seconds_to_utc_calendar_top;

  localparam int EW = euc_pkg::EPOCH_W;
  localparam longint unsigned LAST_EPOCH = 64'(euc_pkg::MAX_EPOCH);
  localparam longint unsigned TOP_EPOCH  = (64'd1 << EW) - 64'd1;
  localparam int STALL_LIMIT    = 2000;
  localparam int ITEMS_PER_PHASE = 92;
  localparam int N_DIRECTED     = 23;

  localparam logic [2:0] CFG_DST_MONTH  = 3'd0;
  localparam logic [2:0] CFG_DST_DAY    = 3'd1;
  localparam logic [2:0] CFG_DST_SECOND = 3'd2;
  localparam logic [2:0] CFG_STD_MONTH  = 3'd3;
  localparam logic [2:0] CFG_STD_DAY    = 3'd4;
  localparam logic [2:0] CFG_STD_SECOND = 3'd5;

  typedef struct packed {
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [8:0]  day_of_year;
    logic [12:0] years_since_1900;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [2:0]  weekday;
    logic        in_daylight;
    logic        out_of_range;
  } calendar_t;

  typedef struct {
    logic [EW-1:0] epoch;
    bit            known;
    calendar_t     cal;
  } request_t;

  localparam calendar_t CAL_NONE   = '0;
  localparam calendar_t CAL_EPOCH0 =
    {6'd0, 6'd0, 5'd0, 9'd0, 13'd70, 4'd0, 5'd1, 3'd4, 1'b0, 1'b0};
  localparam calendar_t CAL_LAST   =
    {6'd59, 6'd59, 5'd23, 9'd364, 13'd8099, 4'd11, 5'd31, 3'd5, 1'b0, 1'b0};
  localparam calendar_t CAL_OOR    = '{out_of_range: 1'b1, default: '0};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [EW-1:0] in_epoch_seconds = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [5:0]  out_second;
  logic [5:0]  out_minute;
  logic [4:0]  out_hour;
  logic [8:0]  out_day_of_year;
  logic [12:0] out_years_since_1900;
  logic [3:0]  out_month;
  logic [4:0]  out_day_of_month;
  logic [2:0]  out_weekday;
  logic        out_in_daylight;
  logic        out_out_of_range;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [16:0] cfg_data = '0;

  // shadow of the daylight-saving registers, reset values
  logic [3:0]  dst_month  = 4'd2;
  logic [4:0]  dst_day    = 5'd1;
  logic [16:0] dst_second = 17'd7200;
  logic [3:0]  std_month  = 4'd9;
  logic [4:0]  std_day    = 5'd1;
  logic [16:0] std_second = 17'd10800;

  int send_idle = 0;
  int recv_idle = 0;
  int mismatches = 0;
  int stall_cycles = 0;
  request_t  requests_to_send [$];
  calendar_t calendars_due [$];
  request_t  on_wire;
  calendar_t dut_cal;

  request_t directed_rows [N_DIRECTED] = '{
    '{38'd0,            1'b1, CAL_EPOCH0},
    '{38'd1,            1'b0, CAL_NONE},
    '{38'd59,           1'b0, CAL_NONE},
    '{38'd60,           1'b0, CAL_NONE},
    '{38'd3599,         1'b0, CAL_NONE},
    '{38'd3600,         1'b0, CAL_NONE},
    '{38'd86399,        1'b0, CAL_NONE},
    '{38'd86400,        1'b0, CAL_NONE},
    '{38'd68169600,     1'b0, CAL_NONE},
    '{38'd94694399,     1'b0, CAL_NONE},
    '{38'd946684799,    1'b0, CAL_NONE},
    '{38'd946684800,    1'b0, CAL_NONE},
    '{38'd951782400,    1'b0, CAL_NONE},
    '{38'd4107542399,   1'b0, CAL_NONE},
    '{38'd4107542400,   1'b0, CAL_NONE},
    '{38'd1614563999,   1'b0, CAL_NONE},
    '{38'd1614564000,   1'b0, CAL_NONE},
    '{38'd1633057199,   1'b0, CAL_NONE},
    '{38'd1633057200,   1'b0, CAL_NONE},
    '{38'h20_0000_0000, 1'b0, CAL_NONE},
    '{38'd253402300799, 1'b1, CAL_LAST},
    '{38'd253402300800, 1'b1, CAL_OOR},
    '{38'h3F_FFFF_FFFF, 1'b1, CAL_OOR}
  };

  epoch_seconds_to_utc_calendar_top dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_epoch_seconds     (in_epoch_seconds),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_second           (out_second),
    .out_minute           (out_minute),
    .out_hour             (out_hour),
    .out_day_of_year      (out_day_of_year),
    .out_years_since_1900 (out_years_since_1900),
    .out_month            (out_month),
    .out_day_of_month     (out_day_of_month),
    .out_weekday          (out_weekday),
    .out_in_daylight      (out_in_daylight),
    .out_out_of_range     (out_out_of_range),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  assign dut_cal = {out_second, out_minute, out_hour, out_day_of_year, out_years_since_1900,
                    out_month, out_day_of_month, out_weekday, out_in_daylight,
                    out_out_of_range};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned month_length(int unsigned mon, longint unsigned yr);
    int unsigned lens [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    bit leap;
    leap = ((yr % 4) == 0 && (yr % 100) != 0) || (yr % 400) == 0;
    return lens[mon] + ((mon == 1 && leap) ? 1 : 0);
  endfunction

  function automatic bit daylight_at(int unsigned mon, int unsigned mday, int unsigned sod);
    bit in_season;
    if (std_month > dst_month)
      in_season = mon >= dst_month && mon < std_month;
    else
      in_season = mon >= dst_month || mon < std_month;
    if (!in_season)
      return 1'b0;
    // start month wins when both months coincide
    if (mon == dst_month)
      return mday > dst_day || (mday == dst_day && sod >= dst_second);
    if (mon == std_month)
      return mday < std_day || (mday == std_day && sod < std_second);
    return 1'b1;
  endfunction

  function automatic calendar_t calendar_of(logic [EW-1:0] t);
    longint unsigned days, z, era, doe, yoe, doy, yr, p, yday, rest;
    int unsigned sod, mon;
    calendar_t r;
    r = '0;
    if (t > euc_pkg::MAX_EPOCH) begin
      r.out_of_range = 1'b1;
      return r;
    end
    days = 64'(t) / 86400;
    sod  = int'(64'(t) % 86400);
    // March-based era arithmetic gives the civil year exactly
    z   = days + 719468;
    era = z / 146097;
    doe = z - era * 146097;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    yr  = yoe + era * 400;
    if ((5 * doy + 2) / 153 >= 10)
      yr = yr + 1;
    p    = yr - 1;
    yday = days - (365 * (yr - 1970) + p / 4 - p / 100 + p / 400 - 477);
    rest = yday;
    mon  = 0;
    while (mon < 11 && rest >= month_length(mon, yr)) begin
      rest = rest - month_length(mon, yr);
      mon++;
    end
    r.second           = 6'(sod % 60);
    r.minute           = 6'((sod / 60) % 60);
    r.hour             = 5'(sod / 3600);
    r.day_of_year      = 9'(yday);
    r.years_since_1900 = 13'(yr - 1900);
    r.month            = 4'(mon);
    r.day_of_month     = 5'(rest + 1);
    r.weekday          = 3'((days + 4) % 7);
    r.in_daylight      = daylight_at(mon, int'(rest) + 1, sod);
    return r;
  endfunction

  // day count since 1970 for a civil date, month one-based; day may spill over
  function automatic longint days_since_1970(int y, int m, int d);
    int yy, era, yoe, mm, doy, doe;
    yy  = (m <= 2) ? y - 1 : y;
    era = yy / 400;
    yoe = yy - era * 400;
    mm  = (m > 2) ? m - 3 : m + 9;
    doy = (153 * mm + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return longint'(era) * 146097 + doe - 719468;
  endfunction

  function automatic logic [EW-1:0] random_epoch();
    longint unsigned raw;
    longint e;
    int unsigned pick, yr, mon;
    int day, sod;
    pick = $urandom_range(99);
    raw  = {$urandom, $urandom};
    if (pick < 40)
      return EW'(raw % (LAST_EPOCH + 1));
    if (pick < 50)
      return EW'(LAST_EPOCH + 1 + raw % (TOP_EPOCH - LAST_EPOCH));
    if (pick < 54) begin
      case ($urandom_range(3))
        0: return '0;
        1: return EW'(LAST_EPOCH);
        2: return EW'(LAST_EPOCH + 1);
        default: return EW'(TOP_EPOCH);
      endcase
    end
    if (pick < 72) begin
      // around new year or the end of February, often on century years
      yr = $urandom_range(1) ? 100 * $urandom_range(20, 99) : $urandom_range(1971, 9998);
      e  = days_since_1970(yr, $urandom_range(1) ? 1 : 3, 1) * 86400
           + int'($urandom_range(6)) - 3;
      return EW'(e);
    end
    // around a configured daylight-saving switch
    yr = $urandom_range(1971, 9998);
    if ($urandom_range(1)) begin
      mon = dst_month;
      day = dst_day;
      sod = dst_second;
    end else begin
      mon = std_month;
      day = std_day;
      sod = std_second;
    end
    if (mon > 11)
      mon = $urandom_range(11);
    day = day + int'($urandom_range(2)) - 1;
    sod = sod + int'($urandom_range(4)) - 2;
    e = days_since_1970(yr, mon + 1, day) * 86400 + sod;
    return EW'(e);
  endfunction

  task automatic program_regs(input int unsigned dm, dd, ds, sm, sd, ss);
    logic [16:0] vals [8];
    vals = '{17'(dm), 17'(dd), 17'(ds), 17'(sm), 17'(sd), 17'(ss), 17'($urandom),
             17'($urandom)};
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      case (3'(i))
        CFG_DST_MONTH:  dst_month  = vals[i][3:0];
        CFG_DST_DAY:    dst_day    = vals[i][4:0];
        CFG_DST_SECOND: dst_second = vals[i];
        CFG_STD_MONTH:  std_month  = vals[i][3:0];
        CFG_STD_DAY:    std_day    = vals[i][4:0];
        CFG_STD_SECOND: std_second = vals[i];
        default: ;
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (requests_to_send.size() != 0 || in_valid || calendars_due.size() != 0)
      @(posedge clk);
    repeat (euc_pkg::PIPE_DEPTH + 2) @(posedge clk);
  endtask

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : request_side
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        calendars_due.push_back(on_wire.known ? on_wire.cal : calendar_of(on_wire.epoch));
      if (!in_valid || in_ready) begin
        if (requests_to_send.size() != 0 && $urandom_range(99) >= send_idle) begin
          on_wire = requests_to_send.pop_front();
          in_valid         <= 1'b1;
          in_epoch_seconds <= on_wire.epoch;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_side
    calendar_t want;
    if (rst_n && out_valid && out_ready) begin
      if (calendars_due.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %h", $time, dut_cal);
        mismatches++;
      end else begin
        want = calendars_due.pop_front();
        check_field("second", want.second, dut_cal.second);
        check_field("minute", want.minute, dut_cal.minute);
        check_field("hour", want.hour, dut_cal.hour);
        check_field("day_of_year", want.day_of_year, dut_cal.day_of_year);
        check_field("years_since_1900", want.years_since_1900, dut_cal.years_since_1900);
        check_field("month", want.month, dut_cal.month);
        check_field("day_of_month", want.day_of_month, dut_cal.day_of_month);
        check_field("weekday", want.weekday, dut_cal.weekday);
        check_field("in_daylight", want.in_daylight, dut_cal.in_daylight);
        check_field("out_of_range", want.out_of_range, dut_cal.out_of_range);
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin : watchdog
    if ((in_valid && in_ready) || (out_valid && out_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("[epoch_seconds_to_utc_calendar_top] ERROR");
      $finish;
    end
  end

  initial begin : run
    request_t req;
    int unsigned m;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    send_idle = 32;
    recv_idle = 53;
    for (int i = 0; i < N_DIRECTED; i++)
      requests_to_send.push_back(directed_rows[i]);
    wait_drained();

    for (int ph = 1; ph <= 6; ph++) begin
      if (ph <= 1) begin
        send_idle = 32;
        recv_idle = 53;
      end else if (ph <= 3) begin
        send_idle = 53;
        recv_idle = 32;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      case (ph)
        1: begin
          // northern-style season inside the year
          m = $urandom_range(10);
          program_regs(m, $urandom_range(1, 28), $urandom_range(86399),
                       $urandom_range(m + 1, 11), $urandom_range(1, 28),
                       $urandom_range(86399));
        end
        2: begin
          // season wraps round the year end
          m = $urandom_range(10);
          program_regs($urandom_range(m + 1, 11), $urandom_range(31), $urandom_range(86399),
                       m, $urandom_range(31), $urandom_range(86399));
        end
        3: begin
          m = $urandom_range(11);
          program_regs(m, $urandom_range(31), $urandom_range(86399),
                       m, $urandom_range(31), $urandom_range(86399));
        end
        4: program_regs(0, 0, 0, 11, 31, 86399);
        5: program_regs(11, 31, 86399, 0, 0, 0);
        default: begin
          // months past December, a start second never reached, wide day data
          program_regs($urandom_range(11), 17'h1FFFF, $urandom_range(86400, 131071),
                       $urandom_range(12, 15), 0, 131071);
        end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        req.epoch = random_epoch();
        req.known = 1'b0;
        req.cal   = CAL_NONE;
        requests_to_send.push_back(req);
      end
      wait_drained();
    end

    if (mismatches == 0)
      $display("[epoch_seconds_to_utc_calendar_top] OK");
    else
      $display("[epoch_seconds_to_utc_calendar_top] ERROR");
    $finish;
  end

endmodule

### files.f
sv/euc_pkg.sv
sv/euc_pipe_ctrl.sv
sv/euc_day_split.sv
sv/euc_civil.sv
sv/euc_clock.sv
sv/epoch_seconds_to_utc_calendar_top.sv
tb/tb_epoch_seconds_to_utc_calendar_top.sv
